// ===== rtl/srsw_pkg.sv =====
`default_nettype none
package srsw_pkg;

	localparam int unsigned WINDOW_DEF = 16;
	localparam int unsigned SEQ_W = 32;
	localparam int unsigned WIN_REG_W = 5;
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [WIN_REG_W-1:0] WINDOW_RESET = WIN_REG_W'(16);
	localparam logic [SEQ_W-1:0] TOTAL_RESET = SEQ_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PACKET_TOTAL = 1'b0,
		CFG_WINDOW_IN_USE = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_ACKED = 2'd1,
		KIND_IGNORED = 2'd2,
		KIND_FIN = 2'd3
	} kind_t;

	typedef enum logic {
		CMD_ACK = 1'b0,
		CMD_ROUND = 1'b1
	} cmd_t;

	typedef struct packed {
		logic shift;
		logic mark;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/srsw_cell.sv =====
`default_nettype none
module srsw_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire srsw_pkg::cell_ctl_t ctl,
	input wire logic hit,
	input wire logic next_flag,
	output logic flag
);
	import srsw_pkg::*;

	logic flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctl.shift) begin
			flag_q <= next_flag;
		end else if (ctl.mark && hit) begin
			flag_q <= 1'b1;
		end
	end

	assign flag = flag_q;

endmodule
`default_nettype wire

// ===== rtl/selective_repeat_sender_window_core.sv =====
`default_nettype none
// Sender window of a selective-repeat transfer. A request with tuser = 1 (transmit round)
// returns, in ascending order, the sequence number of each unacknowledged packet in
// [base, min(base + window, packet_total)) with tlast on the final one, or a single FIN
// (seq = packet_total) when nothing is pending. A request with tuser = 0 carries an ack
// number in tdata and returns one result: recorded (also for stale acks below base) or
// ignored (at or beyond the window end). The ack marks live in a row of WINDOW cells, cell i
// holding the mark of packet base + i; after an ack the row shifts toward cell 0 one step
// a cycle while base advances. One request is handled at a time: a round scans the window
// slots in order and passes on each pending packet; a recorded ack marks its cell and
// slides the row first; a stale or ignored ack or a FIN round goes straight to its result.
// The output register lets a new request be taken while the last result still waits.
// Reset clears all marks at once. Configuration (index 0 packet_total, index 1
// window_in_use) is to be written by the user only while idle; the core does not check it.
module selective_repeat_sender_window_core #(
	parameter int unsigned WINDOW = srsw_pkg::WINDOW_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [srsw_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [srsw_pkg::SEQ_W-1:0] cfg_data,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata, // ack_seq
	input wire logic s_axis_tuser, // cmd
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [63:0] m_axis_tdata, // seq_out, window_base
	output logic [1:0] m_axis_tuser, // kind
	output logic m_axis_tlast
);
	import srsw_pkg::*;

	localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned LW = $clog2(WINDOW + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SLIDE,
		ST_PUSH
	} state_t;

	state_t state_q;
	logic [SEQ_W-1:0] total_q;
	logic [WIN_REG_W-1:0] window_q;
	logic [SEQ_W-1:0] base_q;
	logic [LW-1:0] ptr_q;
	logic [LW-1:0] lim_q;
	kind_t res_kind_q;
	logic [SEQ_W-1:0] res_seq_q;
	logic res_last_q;
	logic m_valid_q;
	kind_t m_kind_q;
	logic [SEQ_W-1:0] m_seq_q;
	logic [SEQ_W-1:0] m_base_q;
	logic m_last_q;

	logic [WINDOW-1:0] flags;
	cell_ctl_t ctl;
	logic [IW-1:0] mark_idx;

	logic accept;
	logic can_load;
	logic push;
	logic [LW-1:0] w_eff;
	logic [SEQ_W-1:0] remain;
	logic [LW-1:0] lim_acc;
	logic [SEQ_W-1:0] ack_off;
	logic ack_stale;
	logic ack_in_win;
	logic [WINDOW-1:0] pend_acc;
	logic [WINDOW-1:0] pend_scan;
	logic [WINDOW-1:0] above_ptr;
	logic pend_now;
	logic last_now;
	logic slide_go;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign can_load = !m_valid_q || m_axis_tready;
	assign push = (state_q == ST_PUSH) && can_load;

	always_comb begin
		if (window_q == '0) begin
			w_eff = LW'(1);
		end else if (32'(window_q) > 32'(WINDOW)) begin
			w_eff = LW'(WINDOW);
		end else begin
			w_eff = LW'(window_q);
		end
	end

	always_comb begin
		remain = total_q - base_q;
		if (total_q <= base_q) begin
			lim_acc = '0;
		end else if (remain < SEQ_W'(w_eff)) begin
			lim_acc = LW'(remain);
		end else begin
			lim_acc = w_eff;
		end
	end

	assign ack_off = s_axis_tdata - base_q;
	assign ack_stale = s_axis_tdata < base_q;
	assign ack_in_win = !ack_stale && (ack_off < SEQ_W'(lim_acc));

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			pend_acc[i] = !flags[i] && (LW'(i) < lim_acc);
			pend_scan[i] = !flags[i] && (LW'(i) < lim_q);
			above_ptr[i] = LW'(i) > ptr_q;
		end
	end

	assign pend_now = (ptr_q < lim_q) && !flags[ptr_q[IW-1:0]];
	assign last_now = !(|(pend_scan & above_ptr));
	assign slide_go = (base_q < total_q) && flags[0];

	always_comb begin
		ctl.shift = (state_q == ST_SLIDE) && slide_go;
		ctl.mark = accept && (cmd_t'(s_axis_tuser) == CMD_ACK) && ack_in_win;
		mark_idx = ack_off[IW-1:0];
	end

	for (genvar g = 0; g < WINDOW; g++) begin : g_cell
		logic next_flag;
		if (g == WINDOW - 1) begin : g_tail
			assign next_flag = 1'b0;
		end else begin : g_link
			assign next_flag = flags[g + 1];
		end
		srsw_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.hit(mark_idx == IW'(g)),
			.next_flag(next_flag),
			.flag(flags[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= TOTAL_RESET;
			window_q <= WINDOW_RESET;
			base_q <= '0;
			ptr_q <= '0;
			lim_q <= '0;
			res_kind_q <= KIND_DATA;
			res_seq_q <= '0;
			res_last_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_kind_q <= KIND_DATA;
			m_seq_q <= '0;
			m_base_q <= '0;
			m_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_PACKET_TOTAL: total_q <= cfg_data;
					CFG_WINDOW_IN_USE: window_q <= cfg_data[WIN_REG_W-1:0];
					default: ;
				endcase
			end
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_last_q <= 1'b1;
						if (cmd_t'(s_axis_tuser) == CMD_ROUND) begin
							if (|pend_acc) begin
								ptr_q <= '0;
								lim_q <= lim_acc;
								state_q <= ST_SCAN;
							end else begin
								res_kind_q <= KIND_FIN;
								res_seq_q <= total_q;
								state_q <= ST_PUSH;
							end
						end else begin
							res_seq_q <= s_axis_tdata;
							if (ack_stale) begin
								res_kind_q <= KIND_ACKED;
								state_q <= ST_PUSH;
							end else if (!ack_in_win) begin
								res_kind_q <= KIND_IGNORED;
								state_q <= ST_PUSH;
							end else begin
								res_kind_q <= KIND_ACKED;
								state_q <= ST_SLIDE;
							end
						end
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + LW'(1);
					if (pend_now) begin
						res_kind_q <= KIND_DATA;
						res_seq_q <= base_q + SEQ_W'(ptr_q);
						res_last_q <= last_now;
						state_q <= ST_PUSH;
					end
				end
				ST_SLIDE: begin
					if (slide_go) begin
						base_q <= base_q + SEQ_W'(1);
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push) begin
						m_kind_q <= res_kind_q;
						m_seq_q <= res_seq_q;
						m_last_q <= res_last_q;
						m_base_q <= base_q;
						state_q <= res_last_q ? ST_IDLE : ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {m_base_q, m_seq_q};
	assign m_axis_tuser = m_kind_q;
	assign m_axis_tlast = m_last_q;

endmodule
`default_nettype wire

// ===== test/selective_repeat_sender_window_core_tb.sv =====
`timescale 1ns / 100ps

module selective_repeat_sender_window_core_tb;
	import srsw_pkg::*;

	localparam int unsigned WIN = WINDOW_DEF;
	localparam int SETTLE = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		kind_t kind;
		logic [SEQ_W-1:0] seq;
		logic last;
		logic [SEQ_W-1:0] wbase;
	} window_result_t;

	class sender_window_checker;
		logic [SEQ_W-1:0] total;
		logic [WIN_REG_W-1:0] win_reg;
		logic [SEQ_W-1:0] base;
		bit acked [WIN];
		window_result_t owed_results[$];
		int errors;
		int requests;
		int results;

		function new();
			total = TOTAL_RESET;
			win_reg = WINDOW_RESET;
			base = '0;
			foreach (acked[i])
				acked[i] = 1'b0;
			errors = 0;
			requests = 0;
			results = 0;
		endfunction

		function int unsigned eff_window();
			if (win_reg == 0)
				return 1;
			if (win_reg > WIN)
				return WIN;
			return win_reg;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void owe(kind_t kind, logic [SEQ_W-1:0] seq, logic last);
			window_result_t r;
			r.kind = kind;
			r.seq = seq;
			r.last = last;
			r.wbase = base;
			owed_results.push_back(r);
		endfunction

		function void note_request(cmd_t cmd, logic [SEQ_W-1:0] ack);
			logic [SEQ_W:0] wend;
			logic [SEQ_W:0] s;
			int n;
			requests++;
			n = 0;
			wend = {1'b0, base} + eff_window();
			if (wend > {1'b0, total})
				wend = {1'b0, total};
			if (cmd == CMD_ROUND) begin
				if ({1'b0, base} >= wend) begin
					owe(KIND_FIN, total, 1'b1);
					return;
				end
				for (s = {1'b0, base}; s < wend; s++) begin
					if (!acked[s % WIN] && n < WIN) begin
						owe(KIND_DATA, s[SEQ_W-1:0], 1'b0);
						n++;
					end
				end
				if (n == 0)
					owe(KIND_FIN, total, 1'b1);
				else
					owed_results[owed_results.size()-1].last = 1'b1;
				return;
			end
			if (ack < base) begin
				owe(KIND_ACKED, ack, 1'b1);
				return;
			end
			if ({1'b0, ack} >= wend) begin
				owe(KIND_IGNORED, ack, 1'b1);
				return;
			end
			acked[ack % WIN] = 1'b1;
			while (base < total && acked[base % WIN]) begin
				acked[base % WIN] = 1'b0;
				base++;
			end
			owe(KIND_ACKED, ack, 1'b1);
		endfunction

		function void check_result(kind_t kind, logic [SEQ_W-1:0] seq, logic last,
				logic [SEQ_W-1:0] wbase);
			window_result_t want;
			results++;
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind %0d seq %0d last %0d base %0d",
						kind, seq, last, wbase);
				return;
			end
			want = owed_results.pop_front();
			if (kind !== want.kind || seq !== want.seq || last !== want.last ||
					wbase !== want.wbase) begin
				errors++;
				if (errors <= 10)
					$display("result %0d: expected kind %0d seq %0d last %0d base %0d, got kind %0d seq %0d last %0d base %0d",
						results, want.kind, want.seq, want.last, want.wbase,
						kind, seq, last, wbase);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [SEQ_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	logic no_idle;
	int hold_reqs;
	int hold_done;
	int quiet_cycles;
	int phases;

	sender_window_checker sb = new();

	selective_repeat_sender_window_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls, plus a long hold-off on demand
	initial begin
		m_axis_tready = 1'b0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_done) begin
				hold_done++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(kind_t'(m_axis_tuser), m_axis_tdata[31:0], m_axis_tlast,
				m_axis_tdata[63:32]);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_request(cmd_t cmd, logic [31:0] ack);
		while (!no_idle && $urandom_range(0, 99) < 25) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ack;
		s_axis_tuser <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(cmd, ack);
	endtask

	task automatic configure(logic [SEQ_W-1:0] total, logic [WIN_REG_W-1:0] win);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_PACKET_TOTAL;
		cfg_data <= total;
		@(posedge clk);
		sb.total = total;
		cfg_idx <= CFG_WINDOW_IN_USE;
		cfg_data <= SEQ_W'(win);
		@(posedge clk);
		sb.win_reg = win;
		cfg_we <= 1'b0;
		phases++;
	endtask

	initial begin
		int ph;
		int i;
		int pick;
		int unsigned new_win;
		logic [SEQ_W-1:0] new_total;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_PACKET_TOTAL;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_ACK;
		no_idle = 1'b0;
		hold_reqs = 0;
		quiet_cycles = 0;
		phases = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one packet, full window
		send_request(CMD_ROUND, 32'd0);
		send_request(CMD_ACK, 32'd7);
		send_request(CMD_ACK, 32'd0);
		send_request(CMD_ROUND, 32'd0);
		send_request(CMD_ACK, 32'd0);
		// empty transfer, window of zero
		configure(32'd0, 5'd0);
		send_request(CMD_ROUND, 32'hffff_ffff);
		send_request(CMD_ACK, 32'hffff_ffff);
		send_request(CMD_ACK, 32'd0);
		// largest total, window above the maximum
		configure(32'hffff_ffff, 5'd31);
		send_request(CMD_ROUND, 32'd0);
		send_request(CMD_ACK, 32'd3);
		send_request(CMD_ACK, 32'd3);
		send_request(CMD_ACK, 32'd17);
		send_request(CMD_ACK, 32'd16);
		send_request(CMD_ACK, 32'd1);
		send_request(CMD_ACK, 32'd2);
		send_request(CMD_ROUND, 32'd0);
		send_request(CMD_ACK, 32'h8000_0000);
		// single-slot window
		configure(32'd20, 5'd1);
		send_request(CMD_ROUND, 32'd0);
		send_request(CMD_ACK, 32'd5);
		send_request(CMD_ACK, 32'd4);
		// total lowered, window above the maximum
		configure(32'd3, 5'd17);
		send_request(CMD_ROUND, 32'd0);
		send_request(CMD_ACK, 32'd4);
		send_request(CMD_ACK, 32'd6);
		configure(32'd24, 5'd16);
		send_request(CMD_ROUND, 32'd0);

		for (ph = 0; ph < 12; ph++) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: new_total = '1;
				1: new_total = (sb.base == 0) ? '0 : $urandom_range(0, sb.base - 1);
				2: new_total = '0;
				default: new_total = sb.base + $urandom_range(1, 50);
			endcase
			new_win = $urandom_range(0, 31);
			if (ph == 4) begin
				new_total = sb.base + 300;
				new_win = WIN;
			end
			configure(new_total, WIN_REG_W'(new_win));
			no_idle <= (ph == 2);
			// hold the result side while rounds keep coming
			if (ph == 4)
				hold_reqs <= hold_reqs + 1;
			for (i = 0; i < 25; i++) begin
				pick = $urandom_range(0, 99);
				if (ph == 4 || pick < 20)
					send_request(CMD_ROUND, $urandom());
				else if (pick < 75)
					send_request(CMD_ACK, sb.base + $urandom_range(0, sb.eff_window() - 1));
				else if (pick < 85 && sb.base != 0)
					send_request(CMD_ACK, $urandom_range(0, sb.base - 1));
				else
					send_request(CMD_ACK, $urandom());
			end
		end

		s_axis_tvalid <= 1'b0;
		no_idle <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d requests and %0d results over %0d register settings",
			sb.requests, sb.results, phases);
		$display("window base reached %0d, %0d errors", sb.base, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/srsw_pkg.sv
rtl/srsw_cell.sv
rtl/selective_repeat_sender_window_core.sv
test/selective_repeat_sender_window_core_tb.sv
